// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions of the sorted priority queue
// Default sizes, result status codes and the control word that the queue
// broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 16;
    localparam int TAG_WIDTH_DEF = 16;

    localparam int STATUS_WIDTH = 2;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

    // Broadcast to all cells: at most one of the two is set in a cycle.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one key and tag. On a push it keeps its entry, takes the new entry
// or takes the entry of the cell above; on a pop it takes the cell below.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF
) (
    input  logic                  clk,
    input  spq_pkg::cell_ctl_t    ctl,
    input  logic [KEY_WIDTH-1:0]  in_key,
    input  logic [TAG_WIDTH-1:0]  in_tag,
    input  logic                  occupied,
    input  logic                  upper_gt,
    input  logic [KEY_WIDTH-1:0]  upper_key,
    input  logic [TAG_WIDTH-1:0]  upper_tag,
    input  logic [KEY_WIDTH-1:0]  lower_key,
    input  logic [TAG_WIDTH-1:0]  lower_tag,
    output logic                  gt,
    output logic [KEY_WIDTH-1:0]  key,
    output logic [TAG_WIDTH-1:0]  tag
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic [TAG_WIDTH-1:0] tag_next;

    // The held entries are sorted, so the cells with gt set form a prefix
    // from the top; the new entry lands in the first cell without it.
    assign gt = occupied && (key_reg > in_key);

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctl.push)
        begin
            if (gt)
            begin
                key_next = key_reg;
                tag_next = tag_reg;
            end
            else if (upper_gt)
            begin
                key_next = in_key;
                tag_next = in_tag;
            end
            else
            begin
                key_next = upper_key;
                tag_next = upper_tag;
            end
        end
        else if (ctl.pop)
        begin
            key_next = lower_key;
            tag_next = lower_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue on a chain of sorted cells
// Push inserts a key and tag in order, pop returns the highest key.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ channel: action 0 pushes key and tag, action 1
// pops the entry with the highest key. Among equal keys the entry pushed
// last is popped first. Every request gives exactly one result on the m_
// channel with the popped key and tag (zero otherwise), a status (ok, pop
// on empty, push on full and dropped) and the count held afterwards.
// The result appears in the cycle after the request is taken, from an
// output register. One request is taken per cycle unless stalled: every
// cell compares its key with the broadcast key in parallel and moves one
// slot in the same cycle. While a result waits unread, s_tready is low
// unless m_tready is high, so no result is lost when the receiver stalls.
// Reset empties the queue at once; there is no clearing pass, and the
// contents of empty cells are never shown.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF,
    parameter int CNT_WIDTH = $clog2(CAPACITY + 1),
    parameter int IN_WIDTH  = ((1 + KEY_WIDTH + TAG_WIDTH + 7) / 8) * 8,
    parameter int OUT_WIDTH =
        ((KEY_WIDTH + TAG_WIDTH + spq_pkg::STATUS_WIDTH + CNT_WIDTH + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_WIDTH-1:0]  s_tdata,   // action, key, tag
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_WIDTH-1:0] m_tdata    // out_key, out_tag, status, count
);

    localparam int SW      = spq_pkg::STATUS_WIDTH;
    localparam int RES_W   = KEY_WIDTH + TAG_WIDTH + SW + CNT_WIDTH;

    logic                 action;
    logic [KEY_WIDTH-1:0] in_key;
    logic [TAG_WIDTH-1:0] in_tag;
    logic                 accept;
    logic                 full;
    logic                 empty;
    spq_pkg::cell_ctl_t   ctl;

    logic [CNT_WIDTH-1:0] count_reg;
    logic [CNT_WIDTH-1:0] count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [KEY_WIDTH-1:0] out_key_reg;
    logic [KEY_WIDTH-1:0] out_key_next;
    logic [TAG_WIDTH-1:0] out_tag_reg;
    logic [TAG_WIDTH-1:0] out_tag_next;
    logic [SW-1:0]        status_reg;
    logic [SW-1:0]        status_next;
    logic [CNT_WIDTH-1:0] out_count_reg;
    logic [CNT_WIDTH-1:0] out_count_next;

    logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [TAG_WIDTH-1:0] cell_tag [CAPACITY];
    logic                 cell_gt  [CAPACITY];

    assign action = s_tdata[0];
    assign in_key = s_tdata[KEY_WIDTH:1];
    assign in_tag = s_tdata[KEY_WIDTH+TAG_WIDTH:KEY_WIDTH+1];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_WIDTH'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign ctl.push = accept && !action && !full;
    assign ctl.pop  = accept && action && !empty;

    // The top of the queue (highest key) is cell 0.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                 up_gt;
        logic [KEY_WIDTH-1:0] up_key;
        logic [TAG_WIDTH-1:0] up_tag;
        logic [KEY_WIDTH-1:0] lo_key;
        logic [TAG_WIDTH-1:0] lo_tag;

        if (i == 0)
        begin : g_top
            assign up_gt  = 1'b1;
            assign up_key = in_key;
            assign up_tag = in_tag;
        end
        else
        begin : g_mid
            assign up_gt  = cell_gt[i-1];
            assign up_key = cell_key[i-1];
            assign up_tag = cell_tag[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_bottom
            assign lo_key = in_key;
            assign lo_tag = in_tag;
        end
        else
        begin : g_upper
            assign lo_key = cell_key[i+1];
            assign lo_tag = cell_tag[i+1];
        end

        spq_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .TAG_WIDTH (TAG_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .in_key    (in_key),
            .in_tag    (in_tag),
            .occupied  (CNT_WIDTH'(i) < count_reg),
            .upper_gt  (up_gt),
            .upper_key (up_key),
            .upper_tag (up_tag),
            .lower_key (lo_key),
            .lower_tag (lo_tag),
            .gt        (cell_gt[i]),
            .key       (cell_key[i]),
            .tag       (cell_tag[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_key_next   = out_key_reg;
        out_tag_next   = out_tag_reg;
        status_next    = status_reg;
        out_count_next = out_count_reg;
        if (ctl.push)
        begin
            count_next = count_reg + CNT_WIDTH'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CNT_WIDTH'(1);
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_key_next   = ctl.pop ? cell_key[0] : '0;
            out_tag_next   = ctl.pop ? cell_tag[0] : '0;
            if (action && empty)
            begin
                status_next = spq_pkg::STATUS_EMPTY;
            end
            else if (!action && full)
            begin
                status_next = spq_pkg::STATUS_FULL;
            end
            else
            begin
                status_next = spq_pkg::STATUS_OK;
            end
            out_count_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_key_reg   <= out_key_next;
        out_tag_reg   <= out_tag_next;
        status_reg    <= status_next;
        out_count_reg <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_WIDTH'({out_count_reg, status_reg, out_tag_reg, out_key_reg});

endmodule

// ===== test/spq_test_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_test_pkg: request codes shared by the queue testbench
// The action bit of a request is written by name in the stimulus and decoded
// by name in the checker.
// ----------------------------------------------------------------------------
package spq_test_pkg;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } action_e;

endpackage

// ===== test/sorted_priority_queue_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_check: result checker for the sorted priority queue
// Watches both stream channels, keeps its own sorted copy of the queue and
// compares every result, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module sorted_priority_queue_check #(
    parameter int IN_W  = 40,
    parameter int OUT_W = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               errors,
    output int               pending,
    output int               requests,
    output int               empty_pops,
    output int               full_pushes,
    output int               peak_fill
);

    localparam int CAP = spq_pkg::CAPACITY_DEF;
    localparam int KW  = spq_pkg::KEY_WIDTH_DEF;
    localparam int TW  = spq_pkg::TAG_WIDTH_DEF;
    localparam int SW  = spq_pkg::STATUS_WIDTH;
    localparam int CW  = $clog2(CAP + 1);

    typedef struct packed {
        logic [KW-1:0] key;
        logic [TW-1:0] tag;
        logic [SW-1:0] status;
        logic [CW-1:0] count;
    } outcome_t;

    // Entries sorted by key, the highest key at position held-1.
    logic [KW-1:0] entry_keys [CAP];
    logic [TW-1:0] entry_tags [CAP];
    int            held = 0;

    outcome_t awaited [$];

    int n_err     = 0;
    int n_pending = 0;
    int n_req     = 0;
    int n_empty   = 0;
    int n_full    = 0;
    int n_peak    = 0;

    assign errors      = n_err;
    assign pending     = n_pending;
    assign requests    = n_req;
    assign empty_pops  = n_empty;
    assign full_pushes = n_full;
    assign peak_fill   = n_peak;

    function automatic outcome_t serve_request(logic pop, logic [KW-1:0] k,
                                               logic [TW-1:0] t);
        outcome_t r;
        int       pos;
        r.key    = '0;
        r.tag    = '0;
        r.status = spq_pkg::STATUS_OK;
        if (pop)
        begin
            if (held == 0)
            begin
                r.status = spq_pkg::STATUS_EMPTY;
                n_empty++;
            end
            else
            begin
                held--;
                r.key = entry_keys[held];
                r.tag = entry_tags[held];
            end
        end
        else if (held >= CAP)
        begin
            r.status = spq_pkg::STATUS_FULL;
            n_full++;
        end
        else
        begin
            // The new entry sinks only below strictly greater keys.
            pos = held;
            while (pos > 0 && entry_keys[pos-1] > k)
            begin
                entry_keys[pos] = entry_keys[pos-1];
                entry_tags[pos] = entry_tags[pos-1];
                pos--;
            end
            entry_keys[pos] = k;
            entry_tags[pos] = t;
            held++;
            if (held > n_peak)
                n_peak = held;
        end
        r.count = CW'(held);
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want != got)
        begin
            n_err++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.key    = m_tdata[KW-1:0];
                got.tag    = m_tdata[KW+TW-1:KW];
                got.status = m_tdata[KW+TW+SW-1:KW+TW];
                got.count  = m_tdata[KW+TW+SW+CW-1:KW+TW+SW];
                if (awaited.size() == 0)
                begin
                    n_err++;
                    $display("%0t ns: result with none expected, got data %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = awaited.pop_front();
                    compare_field("out_key", 32'(want.key), 32'(got.key));
                    compare_field("out_tag", 32'(want.tag), 32'(got.tag));
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("count", 32'(want.count), 32'(got.count));
                end
            end
            if (s_tvalid && s_tready)
            begin
                awaited.push_back(serve_request(s_tdata[0] == spq_test_pkg::ACT_POP,
                                                s_tdata[KW:1],
                                                s_tdata[KW+TW:KW+1]));
                n_req++;
            end
            n_pending = awaited.size();
        end
    end

endmodule

// ===== test/sorted_priority_queue_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: testbench of the sorted priority queue
// Drives a directed set of requests covering extreme keys and tags, equal
// keys and pops on an empty queue, then phases of random pushes and pops
// that fill the queue past capacity and drain it again, with bursty
// requests and a stalling receiver. Results are checked in a separate
// checker module.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;

    localparam int KW     = spq_pkg::KEY_WIDTH_DEF;
    localparam int TW     = spq_pkg::TAG_WIDTH_DEF;
    localparam int CW     = $clog2(spq_pkg::CAPACITY_DEF + 1);
    localparam int IN_W   = ((1 + KW + TW + 7) / 8) * 8;
    localparam int OUT_W  = ((KW + TW + spq_pkg::STATUS_WIDTH + CW + 7) / 8) * 8;
    localparam int TARGET = 1150;
    localparam int LIMIT  = 3000;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    int errors;
    int pending;
    int requests;
    int empty_pops;
    int full_pushes;
    int peak_fill;

    int quiet       = 0;
    int stall_left  = 0;
    int stall_mode  = 0;
    int rx_tick     = 0;

    always #4 clk = ~clk;

    sorted_priority_queue uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_priority_queue_check #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .pending     (pending),
        .requests    (requests),
        .empty_pops  (empty_pops),
        .full_pushes (full_pushes),
        .peak_fill   (peak_fill)
    );

    // The receiver switches between always ready, random, mostly stalled
    // and a periodic pattern, picked at random.
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_tick % 5 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet <= 0;
        end
        else if (quiet >= LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", LIMIT);
            $display("FAIL sorted_priority_queue");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the
    // request was taken, with valid still high.
    task automatic send_request(spq_test_pkg::action_e act, logic [KW-1:0] k,
                                logic [TW-1:0] t);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - 1 - KW - TW){1'b0}}, t, k, act};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [KW-1:0] pick_key();
        case ($urandom_range(0, 5))
            0, 1:    return KW'($urandom_range(0, 7));
            2:       return $urandom_range(0, 1) ? {KW{1'b1}} : {KW{1'b0}};
            default: return KW'($urandom_range(0, (1 << KW) - 1));
        endcase
    endfunction

    function automatic logic [TW-1:0] pick_tag();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? {TW{1'b1}} : {TW{1'b0}};
        return TW'($urandom_range(0, (1 << TW) - 1));
    endfunction

    initial
    begin
        int made;
        int seg;
        int seg_len;
        int pop_pct;
        int burst_left;
        spq_test_pkg::action_e act;

        made       = 0;
        seg        = 0;
        burst_left = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty pops, extreme keys and tags, and ties where the
        // entry pushed last must come out first.
        send_request(spq_test_pkg::ACT_POP,  16'h0000, 16'h0000);
        send_request(spq_test_pkg::ACT_PUSH, 16'h0000, 16'h0000);
        send_request(spq_test_pkg::ACT_PUSH, 16'hffff, 16'hffff);
        send_request(spq_test_pkg::ACT_PUSH, 16'h1234, 16'haaaa);
        send_request(spq_test_pkg::ACT_PUSH, 16'h1234, 16'h5555);
        send_request(spq_test_pkg::ACT_PUSH, 16'h0000, 16'h0001);
        send_request(spq_test_pkg::ACT_PUSH, 16'h8000, 16'h8001);
        send_request(spq_test_pkg::ACT_POP,  16'hffff, 16'hffff);
        send_request(spq_test_pkg::ACT_PUSH, 16'hffff, 16'h0002);
        repeat (7) send_request(spq_test_pkg::ACT_POP, 16'h0000, 16'h0000);
        send_request(spq_test_pkg::ACT_POP,  16'h0000, 16'h0000);
        send_request(spq_test_pkg::ACT_POP,  16'hffff, 16'hffff);
        wait_drained();

        // Random phases: filling past capacity, mixed, draining to empty.
        while (made < TARGET)
        begin
            case (seg % 4)
                0:
                begin
                    pop_pct = 10;
                    seg_len = $urandom_range(100, 150);
                end
                1:
                begin
                    pop_pct = 50;
                    seg_len = $urandom_range(60, 140);
                end
                2:
                begin
                    pop_pct = 90;
                    seg_len = $urandom_range(100, 150);
                end
                default:
                begin
                    pop_pct = $urandom_range(30, 70);
                    seg_len = $urandom_range(60, 140);
                end
            endcase
            if (seg_len > TARGET - made)
                seg_len = TARGET - made;
            repeat (seg_len)
            begin
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 15) == 0)
                        idle_cycles($urandom_range(10, 30));
                    else if ($urandom_range(0, 3) != 0)
                        idle_cycles($urandom_range(1, 6));
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 24);
                end
                act = ($urandom_range(0, 99) < pop_pct) ? spq_test_pkg::ACT_POP
                                                        : spq_test_pkg::ACT_PUSH;
                send_request(act, pick_key(), pick_tag());
                made++;
                burst_left--;
            end
            seg++;
            if (seg == 6)
                wait_drained();
        end

        wait_drained();
        repeat (4) @(posedge clk);

        $display("Checked %0d requests in bursts against a stalling receiver, queue depth up to %0d.",
                 requests, peak_fill);
        $display("Pops on an empty queue: %0d, pushes dropped on a full queue: %0d.",
                 empty_pops, full_pushes);
        if (errors == 0)
        begin
            $display("PASS sorted_priority_queue");
        end
        else
        begin
            $display("%0d mismatches found", errors);
            $display("FAIL sorted_priority_queue");
        end
        $finish;
    end

endmodule
